[rtl/srsw_pkg.sv]
package srsw_pkg;

   localparam int RING_SLOTS   = 16;
   localparam int HALF_RING    = RING_SLOTS / 2;
   localparam int SLOT_W       = $clog2(RING_SLOTS);
   localparam int CNT_W        = $clog2(HALF_RING + 1);
   localparam int SLOT_FIELD_W = 4;
   localparam int ADDR_W       = 4;
   localparam int DATA_W       = 32;

   typedef enum logic [1:0] {
      OP_SEND    = 2'd0,
      OP_ACK     = 2'd1,
      OP_TIMEOUT = 2'd2,
      OP_START   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ACT_TRANSMIT = 2'd0,
      ACT_RELOAD   = 2'd1,
      ACT_DONE     = 2'd2,
      ACT_FAILED   = 2'd3
   } action_type;

   typedef logic [1:0] status_type;

   localparam status_type ST_TO_SEND = 2'd0;
   localparam status_type ST_SENT    = 2'd1;
   localparam status_type ST_ACKED   = 2'd2;

   localparam logic [1:0] REG_TOTAL_PACKETS = 2'd0;
   localparam logic [1:0] REG_WINDOW_SIZE   = 2'd1;
   localparam logic [1:0] REG_MAX_ERRORS    = 2'd2;

   function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                  input logic [SLOT_W-1:0] b);
      logic [SLOT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (SLOT_W+1)'(RING_SLOTS)) begin
         s = s - (SLOT_W+1)'(RING_SLOTS);
      end
      return s[SLOT_W-1:0];
   endfunction

   function automatic logic [SLOT_W-1:0] slot_sub(input logic [SLOT_W-1:0] a,
                                                  input logic [SLOT_W-1:0] b);
      logic [SLOT_W:0] s;
      if (a >= b) begin
         s = {1'b0, a} - {1'b0, b};
      end else begin
         s = {1'b0, a} + (SLOT_W+1)'(RING_SLOTS) - {1'b0, b};
      end
      return s[SLOT_W-1:0];
   endfunction

endpackage

[rtl/selective_repeat_sender_window.sv]
// Selective-repeat sender window; slot states sit in a 16-entry, registered-read memory.
// A send or timeout visits each slot of the effective window W, an ack up to W slots after
// marking the acked slot; each slot visited takes a memory read and then an evaluate step.
// A start event clears the counters and slot states and yields no word. One event is in
// flight at a time; result words pass a pending and an output register and hold on a stall.
// Reset is synchronous: all slots read as to-send, counters clear, registers take 0, 4, 10.
module selective_repeat_sender_window
   import srsw_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_operation,
   input  logic [3:0]              req_ack_number,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_action,
   output logic [SLOT_FIELD_W-1:0] rsp_slot,
   output logic                    rsp_last,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [ADDR_W-1:0]       paddr,
   input  logic [DATA_W-1:0]       pwdata,
   output logic [DATA_W-1:0]       prdata,
   output logic                    pready
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ACK_RD,
      S_ACK_EV,
      S_SCAN_RD,
      S_SCAN_EV,
      S_TERM,
      S_FLUSH
   } state_type;

   state_type               state_ff, state_in;
   op_type                  op_ff, op_in;
   logic [SLOT_W-1:0]       ack_ff, ack_in;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic [SLOT_W-1:0]       base_ff, base_in;
   logic [15:0]             sent_ff, sent_in;
   logic [15:0]             acked_ff, acked_in;
   logic [7:0]              err_ff, err_in;
   logic [15:0]             total_ff, total_in;
   logic [3:0]              wsize_ff, wsize_in;
   logic [7:0]              maxerr_ff, maxerr_in;
   logic [RING_SLOTS-1:0]   valid_ff, valid_in;
   logic                    pend_valid_ff, pend_valid_in;
   action_type              pend_action_ff, pend_action_in;
   logic [SLOT_FIELD_W-1:0] pend_slot_ff, pend_slot_in;
   logic                    out_valid_ff, out_valid_in;
   action_type              out_action_ff, out_action_in;
   logic [SLOT_FIELD_W-1:0] out_slot_ff, out_slot_in;
   logic                    out_last_ff, out_last_in;

   status_type              status_mem [RING_SLOTS];
   status_type              rd_data_ff;
   logic                    rd_vld_ff;
   logic                    rd_en;
   logic [SLOT_W-1:0]       rd_addr;
   logic                    wr_en;
   logic [SLOT_W-1:0]       wr_addr;
   status_type              wr_data;

   logic [CNT_W-1:0]        w_eff;
   logic [SLOT_W-1:0]       scan_addr;
   status_type              rd_status;
   logic                    out_free;
   logic                    blocked;
   logic                    emit_go;
   action_type              emit_action;
   logic [SLOT_FIELD_W-1:0] emit_slot;
   logic                    flush_go;
   logic                    term_fail;
   logic                    term_done;
   action_type              term_action;
   logic                    accept;
   logic                    cfg_write;
   logic                    ack_hit;
   logic                    last_k;
   logic [SLOT_W-1:0]       ack_slot;
   logic [SLOT_W-1:0]       ack_off;

   assign pready    = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign cfg_write = psel && penable && pwrite;

   assign rsp_valid  = out_valid_ff;
   assign rsp_action = out_action_ff;
   assign rsp_slot   = out_slot_ff;
   assign rsp_last   = out_last_ff;

   always_comb begin
      if (wsize_ff == 4'd0) begin
         w_eff = CNT_W'(1);
      end else if (32'(wsize_ff) > HALF_RING) begin
         w_eff = CNT_W'(HALF_RING);
      end else begin
         w_eff = CNT_W'(wsize_ff);
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_TOTAL_PACKETS: prdata = DATA_W'(total_ff);
         REG_WINDOW_SIZE:   prdata = DATA_W'(wsize_ff);
         REG_MAX_ERRORS:    prdata = DATA_W'(maxerr_ff);
         default:           prdata = '0;
      endcase
   end

   assign term_fail   = (err_ff >= maxerr_ff);
   assign term_done   = (acked_ff >= total_ff);
   assign term_action = term_fail ? ACT_FAILED : ACT_DONE;

   assign scan_addr = (op_ff == OP_ACK) ? base_ff : slot_add(base_ff, SLOT_W'(k_ff));
   assign rd_status = rd_vld_ff ? rd_data_ff : ST_TO_SEND;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign blocked   = pend_valid_ff && !out_free;
   assign last_k    = (CNT_W'(k_ff + 1'b1) == w_eff);
   assign ack_slot  = SLOT_W'(req_ack_number);
   assign ack_off   = slot_sub(ack_slot, base_ff);
   assign ack_hit   = (32'(req_ack_number) < RING_SLOTS) && (32'(ack_off) < 32'(w_eff));

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      ack_in         = ack_ff;
      k_in           = k_ff;
      base_in        = base_ff;
      sent_in        = sent_ff;
      acked_in       = acked_ff;
      err_in         = err_ff;
      total_in       = total_ff;
      wsize_in       = wsize_ff;
      maxerr_in      = maxerr_ff;
      valid_in       = valid_ff;
      pend_valid_in  = pend_valid_ff;
      pend_action_in = pend_action_ff;
      pend_slot_in   = pend_slot_ff;
      out_valid_in   = out_valid_ff;
      out_action_in  = out_action_ff;
      out_slot_in    = out_slot_ff;
      out_last_in    = out_last_ff;
      rd_en          = 1'b0;
      rd_addr        = scan_addr;
      wr_en          = 1'b0;
      wr_addr        = scan_addr;
      wr_data        = ST_TO_SEND;
      emit_go        = 1'b0;
      emit_action    = ACT_TRANSMIT;
      emit_slot      = '0;
      flush_go       = 1'b0;

      if (cfg_write) begin
         unique case (paddr[3:2])
            REG_TOTAL_PACKETS: total_in  = pwdata[15:0];
            REG_WINDOW_SIZE:   wsize_in  = pwdata[3:0];
            REG_MAX_ERRORS:    maxerr_in = pwdata[7:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in  = op_type'(req_operation);
               ack_in = ack_slot;
               k_in   = '0;
               if (op_type'(req_operation) == OP_START) begin
                  base_in  = '0;
                  sent_in  = '0;
                  acked_in = '0;
                  err_in   = '0;
                  valid_in = '0;
               end else if (term_fail || term_done) begin
                  emit_go     = 1'b1;
                  emit_action = term_action;
                  emit_slot   = '0;
                  state_in    = S_FLUSH;
               end else begin
                  unique case (op_type'(req_operation))
                     OP_SEND: begin
                        state_in = S_SCAN_RD;
                     end
                     OP_TIMEOUT: begin
                        if (err_ff != 8'hFF) begin
                           err_in = err_ff + 8'd1;
                        end
                        state_in = S_SCAN_RD;
                     end
                     OP_ACK: begin
                        err_in   = '0;
                        state_in = ack_hit ? S_ACK_RD : S_SCAN_RD;
                     end
                     OP_START: begin
                        state_in = S_IDLE;
                     end
                  endcase
               end
            end
         end
         S_ACK_RD: begin
            rd_en    = 1'b1;
            rd_addr  = ack_ff;
            state_in = S_ACK_EV;
         end
         S_ACK_EV: begin
            if (rd_status != ST_ACKED) begin
               wr_en   = 1'b1;
               wr_addr = ack_ff;
               wr_data = ST_ACKED;
               if (acked_ff != 16'hFFFF) begin
                  acked_in = acked_ff + 16'd1;
               end
            end
            state_in = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            rd_en    = 1'b1;
            state_in = S_SCAN_EV;
         end
         S_SCAN_EV: begin
            unique case (op_ff)
               OP_SEND: begin
                  if ((rd_status == ST_TO_SEND) && (sent_ff < total_ff)) begin
                     if (!blocked) begin
                        wr_en       = 1'b1;
                        wr_data     = ST_SENT;
                        sent_in     = sent_ff + 16'd1;
                        emit_go     = 1'b1;
                        emit_action = ACT_TRANSMIT;
                        emit_slot   = SLOT_FIELD_W'(scan_addr);
                        k_in        = k_ff + 1'b1;
                        state_in    = last_k ? S_TERM : S_SCAN_RD;
                     end
                  end else begin
                     k_in     = k_ff + 1'b1;
                     state_in = last_k ? S_TERM : S_SCAN_RD;
                  end
               end
               OP_TIMEOUT: begin
                  if (rd_status == ST_SENT) begin
                     wr_en   = 1'b1;
                     wr_data = ST_TO_SEND;
                     if (sent_ff != 16'd0) begin
                        sent_in = sent_ff - 16'd1;
                     end
                  end
                  k_in     = k_ff + 1'b1;
                  state_in = last_k ? S_TERM : S_SCAN_RD;
               end
               OP_ACK: begin
                  if (rd_status == ST_ACKED) begin
                     if (!blocked) begin
                        wr_en       = 1'b1;
                        wr_data     = ST_TO_SEND;
                        base_in     = slot_add(base_ff, SLOT_W'(1));
                        emit_go     = 1'b1;
                        emit_action = ACT_RELOAD;
                        emit_slot   = SLOT_FIELD_W'(slot_add(base_ff, SLOT_W'(w_eff)));
                        k_in        = k_ff + 1'b1;
                        state_in    = last_k ? S_TERM : S_SCAN_RD;
                     end
                  end else begin
                     state_in = S_TERM;
                  end
               end
               OP_START: begin
                  state_in = S_TERM;
               end
            endcase
         end
         S_TERM: begin
            if (term_fail || term_done) begin
               if (!blocked) begin
                  emit_go     = 1'b1;
                  emit_action = term_action;
                  emit_slot   = '0;
                  state_in    = S_FLUSH;
               end
            end else begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            if (pend_valid_ff) begin
               if (out_free) begin
                  flush_go = 1'b1;
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      if (emit_go) begin
         if (pend_valid_ff) begin
            out_valid_in  = 1'b1;
            out_action_in = pend_action_ff;
            out_slot_in   = pend_slot_ff;
            out_last_in   = 1'b0;
         end
         pend_valid_in  = 1'b1;
         pend_action_in = emit_action;
         pend_slot_in   = emit_slot;
      end

      if (flush_go) begin
         out_valid_in  = 1'b1;
         out_action_in = pend_action_ff;
         out_slot_in   = pend_slot_ff;
         out_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         status_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= status_mem[rd_addr];
         rd_vld_ff  <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         base_ff       <= '0;
         sent_ff       <= '0;
         acked_ff      <= '0;
         err_ff        <= '0;
         total_ff      <= 16'd0;
         wsize_ff      <= 4'd4;
         maxerr_ff     <= 8'd10;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         base_ff       <= base_in;
         sent_ff       <= sent_in;
         acked_ff      <= acked_in;
         err_ff        <= err_in;
         total_ff      <= total_in;
         wsize_ff      <= wsize_in;
         maxerr_ff     <= maxerr_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      op_ff          <= op_in;
      ack_ff         <= ack_in;
      k_ff           <= k_in;
      pend_action_ff <= pend_action_in;
      pend_slot_ff   <= pend_slot_in;
      out_action_ff  <= out_action_in;
      out_slot_ff    <= out_slot_in;
      out_last_ff    <= out_last_in;
   end

endmodule

[rtl/srsw_checker.sv]
module srsw_checker
   import srsw_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic [1:0]              req_operation,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [1:0]              rsp_action,
   input logic [SLOT_FIELD_W-1:0] rsp_slot,
   input logic                    rsp_last,
   input logic                    pready
);

   // A start event leaves the block idle in the next cycle and never yields a word.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_operation == OP_START) |=> !req_stall)
      else $error("start event did not return to idle at once");

   // Done and failed words stand alone at the end of an event and carry slot zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_action == ACT_DONE) || (rsp_action == ACT_FAILED))
      |-> rsp_last && (rsp_slot == '0))
      else $error("terminal word malformed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_action) && $stable(rsp_slot)
                                 && $stable(rsp_last))
      else $error("stalled result word changed");

   assert property (@(posedge clock) $past(reset) |-> !rsp_valid && !req_stall)
      else $error("outputs not idle after reset");

   assert property (@(posedge clock) pready)
      else $error("configuration port not ready");

endmodule

bind selective_repeat_sender_window srsw_checker u_srsw_checker (.*);
